// File: rtl/pstc_pkg.sv
// ----------------------------------------------------------------------------
// PostScript token classifier package
// Shared codes, character constants, result type and character class helpers.
// ----------------------------------------------------------------------------
package pstc_pkg;

  localparam int unsigned DefDepthBits  = 8;
  localparam int unsigned DefLengthBits = 16;
  localparam logic [15:0] MaxLengthRst  = 16'd256;
  localparam int unsigned QueueDepth    = 4;

  localparam logic [2:0] PhSkip    = 3'd0;
  localparam logic [2:0] PhComment = 3'd1;
  localparam logic [2:0] PhLt      = 3'd2;
  localparam logic [2:0] PhGt      = 3'd3;
  localparam logic [2:0] PhBody    = 3'd4;
  localparam logic [2:0] PhTilde   = 3'd5;

  localparam logic [3:0] TypUnknown = 4'd0;
  localparam logic [3:0] TypName    = 4'd1;
  localparam logic [3:0] TypString  = 4'd2;
  localparam logic [3:0] TypA85     = 4'd3;
  localparam logic [3:0] TypHex     = 4'd4;
  localparam logic [3:0] TypBDict   = 4'd5;
  localparam logic [3:0] TypEDict   = 4'd6;
  localparam logic [3:0] TypBArray  = 4'd7;
  localparam logic [3:0] TypEArray  = 4'd8;
  localparam logic [3:0] TypBProc   = 4'd9;
  localparam logic [3:0] TypEProc   = 4'd10;
  localparam logic [3:0] TypInt     = 4'd11;
  localparam logic [3:0] TypReal    = 4'd12;
  localparam logic [3:0] TypRadix   = 4'd13;
  localparam logic [3:0] TypToken   = 4'd14;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StBuff    = 2'd2;
  localparam logic [1:0] StEnd     = 2'd3;

  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChLt      = 8'h3C;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpE     = 8'h45;
  localparam logic [7:0] ChUpF     = 8'h46;
  localparam logic [7:0] ChUpZ     = 8'h5A;
  localparam logic [7:0] ChLBrack  = 8'h5B;
  localparam logic [7:0] ChBslash  = 8'h5C;
  localparam logic [7:0] ChRBrack  = 8'h5D;
  localparam logic [7:0] ChLoA     = 8'h61;
  localparam logic [7:0] ChLoE     = 8'h65;
  localparam logic [7:0] ChLoF     = 8'h66;
  localparam logic [7:0] ChLoU     = 8'h75;
  localparam logic [7:0] ChLoZ     = 8'h7A;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;
  localparam logic [7:0] ChTilde   = 8'h7E;

  typedef struct packed {
    logic [3:0]  token_type;
    logic [1:0]  status;
    logic [15:0] length;
    logic        last;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= ChLoA && c <= ChLoZ) || (c >= ChUpA && c <= ChUpZ);
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= ChLoA && c <= ChLoF) || (c >= ChUpA && c <= ChUpF);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == ChLParen) || (c == ChLt) || (c == ChLBrack) || (c == ChRBrack) ||
           (c == ChLBrace) || (c == ChRBrace) || (c == ChSlash) || (c == ChPercent);
  endfunction

  function automatic logic is_e(input logic [7:0] c);
    return (c == ChLoE) || (c == ChUpE);
  endfunction

endpackage

// File: rtl/postscript_token_classifier.sv
// ----------------------------------------------------------------------------
// PostScript token classifier
// Lexes PostScript text one byte per transfer and reports type, status and
// stored length for each token.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while its input side is ready. Each
// byte updates the registered lexer state and pushes zero, one or two results
// into a four-entry result queue that feeds the output port; a byte that ends a
// token and is itself a bracket gives two results, which leave the output port
// one after the other. The input side is ready while the queue has room for two
// results, so with a free-running consumer the input sustains one byte per
// cycle. Configuration writes are always accepted.
module postscript_token_classifier #(
  parameter int unsigned DEPTH_BITS  = pstc_pkg::DefDepthBits,
  parameter int unsigned LENGTH_BITS = pstc_pkg::DefLengthBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_in
  input  logic        s_axis_tuser,   // end_of_stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // token_type, status, length, zero pad
  output logic        m_axis_tlast
);
  import pstc_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;
  localparam int unsigned QPtrBits = $clog2(QueueDepth);

  logic [15:0]            max_len_q;
  logic [2:0]             phase_q, phase_d;
  logic [3:0]             typ_q, typ_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic [DEPTH_BITS-1:0]  depth_q, depth_d;
  logic                   esc_q, esc_d;
  logic                   digit_q, digit_d;
  logic                   expo_q, expo_d;
  logic                   prev_e_q, prev_e_d;

  logic [LENGTH_BITS-1:0] cap;
  logic [7:0]             c;
  logic                   in_fire, out_fire;

  logic [2:0] st_phase;
  logic [3:0] st_typ;
  logic       st_one, st_digit, st_pe, st_emit;
  logic [3:0] st_etyp;
  logic [1:0] st_estat;

  logic       ra_v, rb_v;
  res_t       ra, rb;
  logic [3:0] fin_typ;
  logic [3:0] nt;
  logic       do_store;

  res_t                  q_mem_q [QueueDepth];
  logic [QPtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrBits:0]     fill_q;

  assign c             = s_axis_tdata;
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (fill_q <= (QPtrBits+1)'(QueueDepth - 2));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (fill_q != '0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  always_comb begin
    if (32'(max_len_q) > 32'(LenMax)) begin
      cap = LenMax;
    end else begin
      cap = LENGTH_BITS'(max_len_q);
    end
  end

  always_comb begin
    st_phase = PhSkip;
    st_typ   = TypUnknown;
    st_one   = 1'b0;
    st_digit = 1'b0;
    st_pe    = 1'b0;
    st_emit  = 1'b0;
    st_etyp  = TypUnknown;
    st_estat = StOk;
    priority if (c == ChPercent) begin
      st_phase = PhComment;
    end else if (is_space(c)) begin
      st_phase = PhSkip;
    end else begin
      unique case (c)
        ChSlash: begin
          st_typ   = TypName;
          st_phase = PhBody;
        end
        ChLParen: begin
          st_typ   = TypString;
          st_phase = PhBody;
        end
        ChLt:     st_phase = PhLt;
        ChGt:     st_phase = PhGt;
        ChLBrack: begin
          st_typ  = TypBArray;
          st_emit = 1'b1;
          st_etyp = TypBArray;
        end
        ChRBrack: begin
          st_typ  = TypEArray;
          st_emit = 1'b1;
          st_etyp = TypEArray;
        end
        ChLBrace: begin
          st_typ  = TypBProc;
          st_emit = 1'b1;
          st_etyp = TypBProc;
        end
        ChRBrace: begin
          st_typ  = TypEProc;
          st_emit = 1'b1;
          st_etyp = TypEProc;
        end
        ChRParen: begin
          st_emit  = 1'b1;
          st_estat = StInvalid;
        end
        default: begin
          st_phase = PhBody;
          st_one   = 1'b1;
          st_pe    = is_e(c);
          priority if (is_digit(c)) begin
            st_typ   = TypInt;
            st_digit = 1'b1;
          end else if (c == ChMinus || c == ChPlus) begin
            st_typ = TypInt;
          end else if (c == ChDot) begin
            st_typ = TypReal;
          end else begin
            st_typ = TypToken;
          end
        end
      endcase
    end
  end

  assign fin_typ = ((typ_q == TypInt || typ_q == TypReal) && !digit_q) ? TypToken : typ_q;

  always_comb begin
    phase_d  = phase_q;
    typ_d    = typ_q;
    count_d  = count_q;
    depth_d  = depth_q;
    esc_d    = esc_q;
    digit_d  = digit_q;
    expo_d   = expo_q;
    prev_e_d = prev_e_q;
    ra_v     = 1'b0;
    rb_v     = 1'b0;
    ra       = '0;
    rb       = '0;
    nt       = typ_q;
    do_store = 1'b0;

    if (max_len_q == '0) begin
      phase_d  = PhSkip;
      typ_d    = TypUnknown;
      count_d  = '0;
      depth_d  = '0;
      esc_d    = 1'b0;
      digit_d  = 1'b0;
      expo_d   = 1'b0;
      prev_e_d = 1'b0;
      ra_v     = 1'b1;
      ra       = '{TypUnknown, StBuff, 16'd0, 1'b0};
    end else if (s_axis_tuser) begin
      phase_d = PhSkip;
      ra_v    = 1'b1;
      unique case (phase_q)
        PhBody: begin
          if (count_q == '0) begin
            ra = '{typ_q, StEnd, 16'd0, 1'b0};
          end else begin
            ra = '{TypUnknown, StInvalid, 16'(count_q), 1'b0};
          end
        end
        PhLt, PhGt, PhTilde: ra = '{TypUnknown, StInvalid, 16'(count_q), 1'b0};
        default:             ra = '{TypUnknown, StEnd, 16'd0, 1'b0};
      endcase
    end else begin
      unique case (phase_q)
        PhComment: begin
          if (c == ChLf || c == ChCr) begin
            phase_d = PhSkip;
          end
        end
        PhLt: begin
          count_d  = '0;
          depth_d  = '0;
          esc_d    = 1'b0;
          digit_d  = 1'b0;
          expo_d   = 1'b0;
          prev_e_d = 1'b0;
          priority if (c == ChLt) begin
            typ_d   = TypBDict;
            phase_d = PhSkip;
            ra_v    = 1'b1;
            ra      = '{TypBDict, StOk, 16'd0, 1'b0};
          end else if (c == ChTilde) begin
            typ_d   = TypA85;
            phase_d = PhBody;
          end else if (is_xdigit(c)) begin
            typ_d    = TypHex;
            phase_d  = PhBody;
            count_d  = LENGTH_BITS'(1);
            prev_e_d = is_e(c);
          end else begin
            count_d = count_q;
            phase_d = PhSkip;
            ra_v    = 1'b1;
            ra      = '{TypUnknown, StInvalid, 16'(count_q), 1'b0};
          end
        end
        PhGt: begin
          phase_d = PhSkip;
          ra_v    = 1'b1;
          if (c == ChGt) begin
            typ_d    = TypEDict;
            count_d  = '0;
            depth_d  = '0;
            esc_d    = 1'b0;
            digit_d  = 1'b0;
            expo_d   = 1'b0;
            prev_e_d = 1'b0;
            ra       = '{TypEDict, StOk, 16'd0, 1'b0};
          end else begin
            ra = '{TypUnknown, StInvalid, 16'(count_q), 1'b0};
          end
        end
        PhTilde: begin
          phase_d = PhSkip;
          ra_v    = 1'b1;
          if (c == ChGt) begin
            ra = '{fin_typ, StOk, 16'(count_q), 1'b0};
          end else begin
            ra = '{TypUnknown, StInvalid, 16'(count_q), 1'b0};
          end
        end
        PhBody: begin
          if (typ_q == TypToken || typ_q == TypName || typ_q == TypInt ||
              typ_q == TypReal || typ_q == TypRadix) begin
            if (is_space(c) || is_delim(c)) begin
              ra_v    = 1'b1;
              ra      = '{fin_typ, StOk, 16'(count_q), 1'b0};
              phase_d = PhSkip;
              if (is_delim(c)) begin
                phase_d  = st_phase;
                typ_d    = st_typ;
                count_d  = st_one ? LENGTH_BITS'(1) : '0;
                depth_d  = '0;
                esc_d    = 1'b0;
                digit_d  = st_digit;
                expo_d   = 1'b0;
                prev_e_d = st_pe;
                rb_v     = st_emit;
                rb       = '{st_etyp, st_estat, 16'd0, 1'b1};
              end
            end else begin
              do_store = 1'b1;
              priority if (typ_q == TypRadix) begin
                if (!(is_alpha(c) || is_digit(c))) begin
                  nt = TypToken;
                end
              end else if (typ_q == TypInt && c == ChHash) begin
                nt = TypRadix;
              end else if (typ_q == TypInt && c == ChDot && !expo_q) begin
                nt = TypReal;
              end else if (typ_q == TypInt || typ_q == TypReal) begin
                priority if (c == ChPlus || c == ChMinus) begin
                  if (count_q == '0 || !prev_e_q) begin
                    nt = TypToken;
                  end
                end else if (is_e(c) && digit_q) begin
                  expo_d = 1'b1;
                end else if (is_digit(c)) begin
                  digit_d = 1'b1;
                end else begin
                  nt = TypToken;
                end
              end else begin
                nt = typ_q;
              end
              typ_d = nt;
            end
          end else if (typ_q == TypString) begin
            do_store = 1'b1;
            priority if (esc_q) begin
              esc_d = 1'b0;
            end else if (c == ChLParen) begin
              if (depth_q == '1) begin
                do_store = 1'b0;
                phase_d  = PhSkip;
                ra_v     = 1'b1;
                ra       = '{TypUnknown, StInvalid, 16'(count_q), 1'b0};
              end else begin
                depth_d = depth_q + 1'b1;
              end
            end else if (c == ChRParen) begin
              if (depth_q == '0) begin
                do_store = 1'b0;
                phase_d  = PhSkip;
                ra_v     = 1'b1;
                ra       = '{fin_typ, StOk, 16'(count_q), 1'b0};
              end else begin
                depth_d = depth_q - 1'b1;
              end
            end else if (c == ChBslash) begin
              esc_d = 1'b1;
            end else begin
              esc_d = esc_q;
            end
          end else if (typ_q == TypHex) begin
            priority if (c == ChGt) begin
              phase_d = PhSkip;
              ra_v    = 1'b1;
              ra      = '{fin_typ, StOk, 16'(count_q), 1'b0};
            end else if (is_space(c)) begin
              phase_d = PhBody;
            end else if (!is_xdigit(c)) begin
              phase_d = PhSkip;
              ra_v    = 1'b1;
              ra      = '{TypUnknown, StInvalid, 16'(count_q), 1'b0};
            end else begin
              do_store = 1'b1;
            end
          end else if (typ_q == TypA85) begin
            priority if (c == ChTilde) begin
              phase_d = PhTilde;
            end else if (c < ChBang || (c > ChLoU && c != ChLoZ)) begin
              phase_d = PhSkip;
              ra_v    = 1'b1;
              ra      = '{TypUnknown, StInvalid, 16'(count_q), 1'b0};
            end else begin
              do_store = 1'b1;
            end
          end else begin
            phase_d = PhSkip;
            ra_v    = 1'b1;
            ra      = '{TypUnknown, StInvalid, 16'(count_q), 1'b0};
          end

          if (do_store) begin
            if (count_q >= cap) begin
              phase_d = PhSkip;
              ra_v    = 1'b1;
              ra      = '{TypUnknown, StBuff, 16'(count_q), 1'b0};
            end else begin
              count_d  = count_q + 1'b1;
              prev_e_d = is_e(c);
            end
          end
        end
        default: begin
          phase_d  = st_phase;
          typ_d    = st_typ;
          count_d  = st_one ? LENGTH_BITS'(1) : '0;
          depth_d  = '0;
          esc_d    = 1'b0;
          digit_d  = st_digit;
          expo_d   = 1'b0;
          prev_e_d = st_pe;
          ra_v     = st_emit;
          ra       = '{st_etyp, st_estat, 16'd0, 1'b0};
        end
      endcase
    end
    ra.last = !rb_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLengthRst;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSkip;
      typ_q    <= TypUnknown;
      count_q  <= '0;
      depth_q  <= '0;
      esc_q    <= 1'b0;
      digit_q  <= 1'b0;
      expo_q   <= 1'b0;
      prev_e_q <= 1'b0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      typ_q    <= typ_d;
      count_q  <= count_d;
      depth_q  <= depth_d;
      esc_q    <= esc_d;
      digit_q  <= digit_d;
      expo_q   <= expo_d;
      prev_e_q <= prev_e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && ra_v) begin
      q_mem_q[wr_ptr_q] <= ra;
    end
    if (in_fire && rb_v) begin
      q_mem_q[wr_ptr_q + 1'b1] <= rb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + QPtrBits'(ra_v) + QPtrBits'(rb_v);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + (in_fire ? ((QPtrBits+1)'(ra_v) + (QPtrBits+1)'(rb_v)) : '0)
                       - (QPtrBits+1)'(out_fire);
    end
  end

  assign m_axis_tdata = {2'b00, q_mem_q[rd_ptr_q].length, q_mem_q[rd_ptr_q].status,
                         q_mem_q[rd_ptr_q].token_type};
  assign m_axis_tlast = q_mem_q[rd_ptr_q].last;

endmodule

// File: rtl/pstc_checker.sv
// ----------------------------------------------------------------------------
// PostScript token classifier checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module pstc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import pstc_pkg::*;

  // A stalled result transfer holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Error results carry no token type.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[5:4] == StInvalid || m_axis_tdata[5:4] == StBuff) |->
      m_axis_tdata[3:0] == TypUnknown)
    else $error("error result with nonzero type");

  // Brackets and end-of-input results report no stored bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[5:4] == StEnd ||
      (m_axis_tdata[3:0] >= TypBDict && m_axis_tdata[3:0] <= TypEProc)) |->
      m_axis_tdata[21:6] == 16'd0)
    else $error("bracket or end result with nonzero length");

  // A result that is not the last of its byte is a completed token, never an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[5:4] == StOk)
    else $error("non-final result with error status");

endmodule

bind postscript_token_classifier pstc_checker u_pstc_checker (.*);
